### design/counter_priority_task_scheduler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the counter/priority task scheduler
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define CPTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CPTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define CPTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### design/cpts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpts_pkg
// Shared types and constants of the counter/priority task scheduler.
// ---------------------------------------------------------------------------
package cpts_pkg;

  localparam int unsigned CNT_W     = 8;
  localparam int unsigned PRI_W     = 8;
  localparam int unsigned WORD_W    = CNT_W + PRI_W;
  localparam int unsigned TASK_ID_W = 6;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [1:0] {
    MODE_SPAWN = 2'd0,
    MODE_FORK  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_SCHED = 2'd3
  } mode_e;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

endpackage

### design/cpts_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cpts_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module cpts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/counter_priority_task_scheduler.sv
`timescale 1ns / 1ps
// One transaction at a time: the next is taken only after the prior result has moved
// into the output register, so a stalled output also holds off the next transaction.
// Reset: asynchronous, active low; used bits reset to slot 0 only. The slot RAM is
// not cleared: a slot is always written when it becomes used, before any read.
// ---------------------------------------------------------------------------
// counter_priority_task_scheduler
// Task table with spawn, fork, timer tick and counter/priority scheduling.
// ---------------------------------------------------------------------------
module counter_priority_task_scheduler
  import cpts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic [PRI_W-1:0]     new_priority_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [TASK_ID_W-1:0] task_id_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic                 switched_o
);

  localparam int unsigned IDX_W = $clog2(TASK_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e                state_q;
  mode_e                 mode_q;
  logic [TASK_SLOTS-1:0] used_q;
  logic [IDX_W-1:0]      run_q;
  logic [IDX_W-1:0]      scan_idx_q;
  logic                  scan_on_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  reload_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [CNT_W-1:0]      best_cnt_q;
  logic [TASK_ID_W-1:0]  res_id_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic                  res_sw_q;
  logic                  out_valid_q;
  logic [TASK_ID_W-1:0]  out_id_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_sw_q;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic                  in_fire;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [WORD_W-1:0]     cur_word;
  logic [CNT_W-1:0]      cur_cnt;
  logic [PRI_W-1:0]      cur_pri;
  logic                  rd_used;
  logic [CNT_W-1:0]      scan_cnt;
  logic                  take;
  logic [IDX_W-1:0]      best_idx_d;
  logic [CNT_W-1:0]      best_cnt_d;
  logic                  pass_end;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Find the lowest free slot above the idle slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 1; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Entry of the running task; the idle slot is never written and reads zero
  assign cur_word = (run_q != '0) ? ram_rdata : '0;
  assign cur_cnt  = cur_word[CNT_W-1:0];
  assign cur_pri  = cur_word[WORD_W-1:CNT_W];

  // Scan compare: reload pass sees the priority as the new counter
  assign rd_used    = used_q[rd_idx_q];
  assign scan_cnt   = reload_q ? ram_rdata[WORD_W-1:CNT_W] : ram_rdata[CNT_W-1:0];
  assign take       = rd_vld_q && rd_used && (scan_cnt > best_cnt_q);
  assign best_idx_d = take ? rd_idx_q : best_idx_q;
  assign best_cnt_d = take ? scan_cnt : best_cnt_q;
  assign pass_end   = rd_vld_q && (rd_idx_q == LAST_IDX);

  // Drive the slot RAM ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx;
    ram_wdata = cur_word;
    ram_raddr = (state_q == S_SCAN) ? scan_idx_q : run_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && mode_e'(mode_i) == MODE_SPAWN) begin
          ram_we    = free_found;
          ram_wdata = {new_priority_i, CNT_W'(0)};
        end
      end
      S_RMW: begin
        if (mode_q == MODE_FORK) begin
          ram_we = free_found;
        end else begin
          ram_we    = (run_q != '0) && (cur_cnt != '0);
          ram_waddr = run_q;
          ram_wdata = {cur_pri, cur_cnt - CNT_W'(1)};
        end
      end
      S_SCAN: begin
        ram_we    = reload_q && rd_vld_q && rd_used;
        ram_waddr = rd_idx_q;
        ram_wdata = {ram_rdata[WORD_W-1:CNT_W], ram_rdata[WORD_W-1:CNT_W]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cpts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TASK_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, task table bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_SPAWN;
      used_q       <= TASK_SLOTS'(1);
      run_q        <= '0;
      scan_idx_q   <= '0;
      scan_on_q    <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      reload_q     <= 1'b0;
      best_idx_q   <= '0;
      best_cnt_q   <= '0;
      res_id_q     <= '0;
      res_status_q <= ST_OK;
      res_sw_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_status_q <= ST_OK;
      out_sw_q     <= 1'b0;
    end else begin
      // Drop the output once taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            mode_q   <= mode_e'(mode_i);
            res_sw_q <= 1'b0;
            case (mode_e'(mode_i))
              MODE_SPAWN: begin
                if (free_found) begin
                  used_q[free_idx] <= 1'b1;
                  res_id_q         <= TASK_ID_W'(free_idx);
                  res_status_q     <= ST_OK;
                end else begin
                  res_id_q     <= TASK_ID_W'(run_q);
                  res_status_q <= ST_FULL;
                end
                state_q <= S_FINISH;
              end
              MODE_FORK, MODE_TICK: begin
                state_q <= S_RMW;
              end
              MODE_SCHED: begin
                scan_idx_q <= IDX_W'(1);
                scan_on_q  <= 1'b1;
                rd_vld_q   <= 1'b0;
                reload_q   <= 1'b0;
                best_idx_q <= '0;
                best_cnt_q <= '0;
                state_q    <= S_SCAN;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_RMW: begin
          if (mode_q == MODE_FORK && free_found) begin
            used_q[free_idx] <= 1'b1;
            res_id_q         <= TASK_ID_W'(free_idx);
            res_status_q     <= ST_OK;
          end else begin
            res_id_q     <= TASK_ID_W'(run_q);
            res_status_q <= (mode_q == MODE_FORK) ? ST_FULL : ST_OK;
          end
          state_q <= S_FINISH;
        end

        S_SCAN: begin
          // Advance the read pointer, one slot per cycle
          rd_vld_q <= scan_on_q;
          rd_idx_q <= scan_idx_q;
          if (scan_on_q) begin
            if (scan_idx_q == LAST_IDX) begin
              scan_on_q <= 1'b0;
            end else begin
              scan_idx_q <= scan_idx_q + IDX_W'(1);
            end
          end
          best_idx_q <= best_idx_d;
          best_cnt_q <= best_cnt_d;

          if (pass_end) begin
            if (!reload_q && best_idx_d == '0) begin
              // Every counter ran out: reload from priorities and pick again
              reload_q   <= 1'b1;
              scan_idx_q <= IDX_W'(1);
              scan_on_q  <= 1'b1;
              rd_vld_q   <= 1'b0;
              best_idx_q <= '0;
              best_cnt_q <= '0;
            end else begin
              if (best_idx_d == '0) begin
                res_id_q     <= TASK_ID_W'(run_q);
                res_status_q <= ST_NONE;
                res_sw_q     <= 1'b0;
              end else begin
                res_id_q     <= TASK_ID_W'(best_idx_d);
                res_status_q <= ST_OK;
                res_sw_q     <= (best_idx_d != run_q);
                run_q        <= best_idx_d;
              end
              state_q <= S_FINISH;
            end
          end
        end

        S_FINISH: begin
          // Hold the result until the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_id_q     <= res_id_q;
            out_status_q <= res_status_q;
            out_sw_q     <= res_sw_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign task_id_o   = out_id_q;
  assign status_o    = out_status_q;
  assign switched_o  = out_sw_q;

`include "counter_priority_task_scheduler_assert.svh"

  `CPTS_ASSERT_IMPL(a_idle_slot_used, 1'b1, used_q[0], "idle slot lost its used bit")
  `CPTS_ASSERT_IMPL(a_running_used, 1'b1, used_q[run_q], "running task is not a used slot")
  `CPTS_ASSERT_NEXT(a_busy_after_accept, in_fire, state_q != S_IDLE, "accepted transaction was not started")
  `CPTS_ASSERT_IMPL(a_scan_write_in_reload, ram_we && state_q == S_SCAN, reload_q, "slot RAM written during a plain scan pass")

endmodule
